/* sv/lhae_pkg.sv */
package lhae_pkg;

    // ADC sample width; the half-scale point is the zero of the centered value
    localparam int SAMPLE_BITS = 12;
    localparam int GAIN_W      = 16;
    localparam int ANGLE_W     = 16;
    localparam int SECTOR_W    = 3;

    // centered sample (SAMPLE_BITS signed) times gain (GAIN_W+1 signed)
    localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
    // scaled offset magnitude stays below 2^16
    localparam int V_W    = GAIN_W + 2;
    // sector base plus or minus offset
    localparam int SUM_W  = V_W + 1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

    // sector bases, Q3.13 radians
    localparam logic signed [SUM_W-1:0] BASE_PI_3  = SUM_W'(8578);
    localparam logic signed [SUM_W-1:0] BASE_2PI_3 = SUM_W'(17157);
    localparam logic signed [SUM_W-1:0] BASE_PI    = SUM_W'(25736);
    localparam logic signed [SUM_W-1:0] BASE_4PI_3 = SUM_W'(34315);
    localparam logic signed [SUM_W-1:0] BASE_5PI_3 = SUM_W'(42894);
    localparam logic signed [SUM_W-1:0] BASE_2PI   = SUM_W'(51472);
    localparam logic signed [SUM_W-1:0] ANGLE_MAX  = SUM_W'(51471);

    localparam logic [SECTOR_W-1:0] SEC_1 = SECTOR_W'(1);
    localparam logic [SECTOR_W-1:0] SEC_2 = SECTOR_W'(2);
    localparam logic [SECTOR_W-1:0] SEC_3 = SECTOR_W'(3);
    localparam logic [SECTOR_W-1:0] SEC_4 = SECTOR_W'(4);
    localparam logic [SECTOR_W-1:0] SEC_5 = SECTOR_W'(5);
    localparam logic [SECTOR_W-1:0] SEC_6 = SECTOR_W'(6);

    typedef logic [SAMPLE_BITS-1:0]   t_sample;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_a;
        logic [SAMPLE_BITS-1:0] sample_b;
        logic [SAMPLE_BITS-1:0] sample_c;
    } t_req;

    typedef struct packed {
        logic [ANGLE_W-1:0]  rotor_angle;
        logic [SECTOR_W-1:0] sector;
    } t_rsp;

    // pipeline control from the top level to the merge stage
    typedef struct packed {
        logic en;
    } t_stage_ctl;

    // strict compares, ties fall to the else side
    function automatic logic [SECTOR_W-1:0] pick_sector(
        input t_sample a,
        input t_sample b,
        input t_sample c
    );
        logic [SECTOR_W-1:0] sec;
        if (a > b) begin
            if (a > c) begin
                sec = (b > c) ? SEC_1 : SEC_6;
            end else begin
                sec = SEC_5;
            end
        end else if (b > c) begin
            sec = (a > c) ? SEC_2 : SEC_3;
        end else begin
            sec = SEC_4;
        end
        return sec;
    endfunction

endpackage

/* sv/lhae_lane.sv */
module lhae_lane (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  lhae_pkg::t_sample        i_sample,
    input  logic [lhae_pkg::GAIN_W-1:0] i_gain,
    output lhae_pkg::t_prod          o_prod
);

    logic signed [lhae_pkg::SAMPLE_BITS-1:0] centred;
    logic signed [lhae_pkg::GAIN_W:0]        gain_s;
    lhae_pkg::t_prod                         n_prod;
    lhae_pkg::t_prod                         r_prod;

    // sample - half scale: flip the top bit
    assign centred = {~i_sample[lhae_pkg::SAMPLE_BITS-1],
                      i_sample[lhae_pkg::SAMPLE_BITS-2:0]};
    assign gain_s  = {1'b0, i_gain};
    assign n_prod  = lhae_pkg::PROD_W'(centred * gain_s);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

/* sv/lhae_merge.sv */
module lhae_merge (
    input  logic                             i_clk,
    input  lhae_pkg::t_stage_ctl             i_ctl,
    input  lhae_pkg::t_prod                  i_prod_a,
    input  lhae_pkg::t_prod                  i_prod_b,
    input  lhae_pkg::t_prod                  i_prod_c,
    input  logic [lhae_pkg::SECTOR_W-1:0]    i_sector,
    output lhae_pkg::t_rsp                   o_rsp
);

    localparam int SHIFT = lhae_pkg::SAMPLE_BITS - 1;

    lhae_pkg::t_prod                     sh_a, sh_b, sh_c;
    logic signed [lhae_pkg::SUM_W-1:0]   v_a, v_b, v_c;
    logic signed [lhae_pkg::SUM_W-1:0]   sum;
    lhae_pkg::t_rsp                      n_rsp;
    lhae_pkg::t_rsp                      r_rsp;

    // arithmetic shift = floor division by half scale
    assign sh_a = i_prod_a >>> SHIFT;
    assign sh_b = i_prod_b >>> SHIFT;
    assign sh_c = i_prod_c >>> SHIFT;
    assign v_a  = sh_a[lhae_pkg::SUM_W-1:0];
    assign v_b  = sh_b[lhae_pkg::SUM_W-1:0];
    assign v_c  = sh_c[lhae_pkg::SUM_W-1:0];

    always_comb begin
        case (i_sector)
            lhae_pkg::SEC_1: begin
                // negative offset wraps below zero to just under 2*pi
                sum = v_b[lhae_pkg::SUM_W-1] ? (lhae_pkg::BASE_2PI + v_b) : v_b;
            end
            lhae_pkg::SEC_2: begin
                sum = lhae_pkg::BASE_PI_3 - v_a;
            end
            lhae_pkg::SEC_3: begin
                sum = lhae_pkg::BASE_2PI_3 + v_c;
            end
            lhae_pkg::SEC_4: begin
                sum = lhae_pkg::BASE_PI - v_b;
            end
            lhae_pkg::SEC_5: begin
                sum = lhae_pkg::BASE_4PI_3 + v_a;
            end
            default: begin
                sum = lhae_pkg::BASE_5PI_3 - v_c;
            end
        endcase

        n_rsp.sector = i_sector;
        if (sum[lhae_pkg::SUM_W-1]) begin
            n_rsp.rotor_angle = '0;
        end else if (sum > lhae_pkg::ANGLE_MAX) begin
            n_rsp.rotor_angle = lhae_pkg::ANGLE_MAX[lhae_pkg::ANGLE_W-1:0];
        end else begin
            n_rsp.rotor_angle = sum[lhae_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

/* sv/linear_hall_angle_estimator.sv */
// Channel    Direction  Handshake                Payload
// request    in         i_req_valid/o_req_stall  i_req (sample_a, sample_b, sample_c)
// response   out        o_rsp_valid/i_rsp_stall  o_rsp (rotor_angle, sector)
// config     in         i_cfg_wr_en              i_cfg_wr_data (inverse_amplitude_gain)
//
// Two register stages: lanes multiply, merge shifts/adds/saturates.
// One request per cycle unless stalled; the lane multipliers set the stage timing.
// Reset (synchronous, i_rst_n low) empties both stages and sets the gain to 1.0.
// A stall on the response side backs up only as far as the first empty stage.
module linear_hall_angle_estimator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_stall,
    input  lhae_pkg::t_req                i_req,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_stall,
    output lhae_pkg::t_rsp                o_rsp,
    input  logic                          i_cfg_wr_en,
    input  logic [lhae_pkg::GAIN_W-1:0]   i_cfg_wr_data
);

    // reciprocal amplitude gain, Q4.12
    logic [lhae_pkg::GAIN_W-1:0]   r_gain;

    // stage valids: s1 = lane products, s2 = response register
    logic                          r_s1_valid;
    logic                          r_s2_valid;
    logic                          en_s1;
    logic                          en_s2;

    logic [lhae_pkg::SECTOR_W-1:0] r_sector;
    lhae_pkg::t_prod               prod_a, prod_b, prod_c;
    lhae_pkg::t_stage_ctl          merge_ctl;

    // a stage loads when it is empty or its contents move on
    assign en_s2       = !r_s2_valid || !i_rsp_stall;
    assign en_s1       = !r_s1_valid || en_s2;
    assign o_req_stall = !en_s1;
    assign o_rsp_valid = r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= lhae_pkg::GAIN_RESET;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_gain <= i_cfg_wr_data;
            end
            if (en_s1) begin
                r_s1_valid <= i_req_valid;
            end
            if (en_s2) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // sector from the sample ordering travels beside the products
    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_sector <= lhae_pkg::pick_sector(i_req.sample_a, i_req.sample_b,
                                              i_req.sample_c);
        end
    end

    // one lane per sensor: center and scale every sample, merge picks one
    lhae_lane u_lane_a (
        .i_clk    (i_clk),
        .i_en     (en_s1),
        .i_sample (i_req.sample_a),
        .i_gain   (r_gain),
        .o_prod   (prod_a)
    );

    lhae_lane u_lane_b (
        .i_clk    (i_clk),
        .i_en     (en_s1),
        .i_sample (i_req.sample_b),
        .i_gain   (r_gain),
        .o_prod   (prod_b)
    );

    lhae_lane u_lane_c (
        .i_clk    (i_clk),
        .i_en     (en_s1),
        .i_sample (i_req.sample_c),
        .i_gain   (r_gain),
        .o_prod   (prod_c)
    );

    assign merge_ctl.en = en_s2;

    lhae_merge u_merge (
        .i_clk    (i_clk),
        .i_ctl    (merge_ctl),
        .i_prod_a (prod_a),
        .i_prod_b (prod_b),
        .i_prod_c (prod_c),
        .i_sector (r_sector),
        .o_rsp    (o_rsp)
    );

endmodule
